@@ design/lmn_pkg.sv @@
// Shared constants, codes and controller/datapath bundles for the mutex node.
// Used by the channel interfaces and every module of the block; no dependencies.
package lmn_pkg;

  localparam int LMN_MAX_NODES  = 16;
  localparam int LMN_STAMP_BITS = 16;

  // Fixed field widths of the channels.
  localparam int ACT_W      = 3;
  localparam int NODE_W     = 4;
  localparam int STAMP_W    = 16;
  localparam int KIND_W     = 2;
  localparam int ERR_W      = 2;
  localparam int ACK_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [ACT_W-1:0] ACT_LREQ  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PREQ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PACK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PREL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LEAVE = 3'd4;

  localparam logic [KIND_W-1:0] SEND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] SEND_REQ  = 2'd1;
  localparam logic [KIND_W-1:0] SEND_ACK  = 2'd2;
  localparam logic [KIND_W-1:0] SEND_REL  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 4'd1;

  localparam logic [ACK_W-1:0] ACK_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             ins_local;
    logic             ins_peer;
    logic             ack_inc;
    logic             scan_start;
    logic             scan_match;
    logic             match_own;
    logic             remove;
    logic             leave;
    logic             set_err;
    logic [ERR_W-1:0] err_code;
    logic             set_grant;
    logic             publish;
  } lmn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             scan_done;
    logic             found;
    logic             head_own;
    logic             grant_ok;
    logic             out_free;
  } lmn_stat_t;

endpackage

@@ design/lmn_in_if.sv @@
// Input message channel of the mutex node: valid/ready handshake and one word.
// Depends on lmn_pkg for the field widths.
interface lmn_in_if import lmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [NODE_W-1:0]  peer_id;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, action, peer_id, stamp, input ready);
  modport sink (input valid, action, peer_id, stamp, output ready);
endinterface

@@ design/lmn_out_if.sv @@
// Result channel of the mutex node: valid/ready handshake and one result word.
// Depends on lmn_pkg for the field widths.
interface lmn_out_if import lmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  send_kind;
  logic [NODE_W-1:0]  dest_id;
  logic [STAMP_W-1:0] send_stamp;
  logic               grant;
  logic [ERR_W-1:0]   error;

  modport source (output valid, send_kind, dest_id, send_stamp, grant, error, input ready);
  modport sink (input valid, send_kind, dest_id, send_stamp, grant, error, output ready);
endinterface

@@ design/lmn_cfg_if.sv @@
// Configuration write channel of the mutex node: register index and write data.
// Depends on lmn_pkg for the field widths.
interface lmn_cfg_if import lmn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/lmn_datapath.sv @@
// Datapath of the mutex node: request table, counters, table scanner and result registers.
// Depends on lmn_pkg; driven by lmn_ctrl through lmn_cmd_t.
module lmn_datapath import lmn_pkg::*; #(
  parameter int MAX_NODES  = LMN_MAX_NODES,
  parameter int STAMP_BITS = LMN_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [NODE_W-1:0]     in_peer_id,
  input  logic [STAMP_W-1:0]    in_stamp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  lmn_cmd_t              cmd,
  output lmn_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_send_kind,
  output logic [NODE_W-1:0]     out_dest_id,
  output logic [STAMP_W-1:0]    out_send_stamp,
  output logic                  out_grant,
  output logic [ERR_W-1:0]      out_error
);

  localparam int               IDX_W    = $clog2(MAX_NODES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  // Table memory; an entry is only looked at while its valid bit is set.
  logic [STAMP_BITS-1:0] mem_stamp [MAX_NODES];
  logic [NODE_W-1:0]     mem_node  [MAX_NODES];
  logic [MAX_NODES-1:0]  valid_r;

  logic [ACT_W-1:0]      act_r;
  logic [NODE_W-1:0]     peer_r;
  logic [STAMP_BITS-1:0] stamp_r;

  logic [NODE_W-1:0]     own_id_r;
  logic [NODE_W-1:0]     peer_count_r;
  logic [ACK_W-1:0]      ack_r;
  logic [STAMP_BITS-1:0] clock_r;
  logic                  in_sec_r;

  logic [IDX_W-1:0]      scan_addr_r;
  logic                  scan_run_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [STAMP_BITS-1:0] rd_stamp_r;
  logic [NODE_W-1:0]     rd_node_r;
  logic                  scan_done_r;
  logic                  match_r;
  logic [NODE_W-1:0]     match_node_r;
  logic                  best_found_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [STAMP_BITS-1:0] best_stamp_r;
  logic [NODE_W-1:0]     best_node_r;

  logic [KIND_W-1:0]     res_kind_r;
  logic [NODE_W-1:0]     res_dest_r;
  logic [STAMP_W-1:0]    res_stamp_r;
  logic                  res_grant_r;
  logic [ERR_W-1:0]      res_err_r;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [NODE_W-1:0]     out_dest_r;
  logic [STAMP_W-1:0]    out_stamp_r;
  logic                  out_grant_r;
  logic [ERR_W-1:0]      out_err_r;

  logic [IDX_W-1:0]      free_idx;
  logic [STAMP_BITS-1:0] clock_inc;
  logic                  ins_en;
  logic [STAMP_BITS-1:0] ins_stamp;
  logic [NODE_W-1:0]     ins_node;
  logic                  cand;
  logic                  better;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign clock_inc = clock_r + STAMP_BITS'(1);
  assign ins_en    = cmd.ins_local | cmd.ins_peer;
  assign ins_stamp = cmd.ins_local ? clock_inc : stamp_r;
  assign ins_node  = cmd.ins_local ? own_id_r : peer_r;

  // The scanner keeps the first entry in (stamp, node) order; on equal keys the
  // lower index wins because only a strictly smaller key replaces the best.
  assign cand   = rd_vld_r && valid_r[rd_idx_r] && (!match_r || (rd_node_r == match_node_r));
  assign better = !best_found_r || ({rd_stamp_r, rd_node_r} < {best_stamp_r, best_node_r});

  always_ff @(posedge clk) begin
    if (ins_en) begin
      mem_stamp[free_idx] <= ins_stamp;
      mem_node[free_idx]  <= ins_node;
    end
    rd_stamp_r <= mem_stamp[scan_addr_r];
    rd_node_r  <= mem_node[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      own_id_r     <= '0;
      peer_count_r <= NODE_W'(1);
      ack_r        <= '0;
      clock_r      <= '0;
      in_sec_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ins_en) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (cmd.remove) begin
        valid_r[best_idx_r] <= 1'b0;
      end
      if (cfg_we && (cfg_index == CFG_OWN_ID)) begin
        own_id_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_PEER_COUNT)) begin
        peer_count_r <= cfg_data;
      end
      if (cmd.ins_local) begin
        clock_r <= clock_inc;
      end
      if (cmd.ack_inc && (ack_r != ACK_MAX)) begin
        ack_r <= ack_r + ACK_W'(1);
      end
      if (cmd.leave) begin
        ack_r    <= '0;
        in_sec_r <= 1'b0;
      end
      if (cmd.set_grant) begin
        in_sec_r <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scanner: one address a cycle, the read data registered in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_run_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_done_r <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_run_r  <= 1'b1;
      rd_vld_r    <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      rd_vld_r    <= scan_run_r;
      scan_done_r <= rd_vld_r && (rd_idx_r == LAST_IDX);
      if (scan_run_r && (scan_addr_r == LAST_IDX)) begin
        scan_run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr_r  <= '0;
      best_found_r <= 1'b0;
      match_r      <= cmd.scan_match;
      match_node_r <= cmd.match_own ? own_id_r : peer_r;
    end else begin
      if (scan_run_r) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      if (cand && better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= rd_idx_r;
        best_stamp_r <= rd_stamp_r;
        best_node_r  <= rd_node_r;
      end
    end
    rd_idx_r <= scan_addr_r;
  end

  // Item and result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= in_action;
      peer_r      <= in_peer_id;
      stamp_r     <= STAMP_BITS'(in_stamp);
      res_kind_r  <= SEND_NONE;
      res_dest_r  <= '0;
      res_stamp_r <= '0;
      res_grant_r <= 1'b0;
      res_err_r   <= ERR_OK;
    end else begin
      if (cmd.ins_local) begin
        res_kind_r  <= SEND_REQ;
        res_stamp_r <= STAMP_W'(clock_inc);
      end
      if (cmd.ins_peer) begin
        res_kind_r <= SEND_ACK;
        res_dest_r <= peer_r;
      end
      if (cmd.leave) begin
        res_kind_r <= SEND_REL;
      end
      if (cmd.set_err) begin
        res_err_r <= cmd.err_code;
      end
      if (cmd.set_grant) begin
        res_grant_r <= 1'b1;
      end
    end
    if (cmd.publish) begin
      out_kind_r  <= res_kind_r;
      out_dest_r  <= res_dest_r;
      out_stamp_r <= res_stamp_r;
      out_grant_r <= res_grant_r;
      out_err_r   <= res_err_r;
    end
  end

  always_comb begin
    stat.act       = act_r;
    stat.full      = &valid_r;
    stat.scan_done = scan_done_r;
    stat.found     = best_found_r;
    stat.head_own  = (best_node_r == own_id_r);
    stat.grant_ok  = !in_sec_r && (ack_r == peer_count_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_send_kind  = out_kind_r;
  assign out_dest_id    = out_dest_r;
  assign out_send_stamp = out_stamp_r;
  assign out_grant      = out_grant_r;
  assign out_error      = out_err_r;

endmodule

@@ design/lmn_ctrl.sv @@
// Controller of the mutex node: sequences insert, removal scans and the grant check.
// Depends on lmn_pkg; commands lmn_datapath through lmn_cmd_t.
module lmn_ctrl import lmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lmn_stat_t stat,
  output lmn_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_GCHK,
    S_HEAD,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.act)
          ACT_LREQ, ACT_PREQ: begin
            if (stat.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_FULL;
            end else begin
              cmd.ins_local = (stat.act == ACT_LREQ);
              cmd.ins_peer  = (stat.act == ACT_PREQ);
            end
          end
          ACT_PACK: begin
            cmd.ack_inc = 1'b1;
            state_nxt   = S_GCHK;
          end
          ACT_PREL, ACT_LEAVE: begin
            cmd.scan_start = 1'b1;
            cmd.scan_match = 1'b1;
            cmd.match_own  = (stat.act == ACT_LEAVE);
            state_nxt      = S_FIND;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_FIND: begin
        if (stat.scan_done) begin
          if (!stat.found) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_MISSING;
            state_nxt    = S_DONE;
          end else begin
            cmd.remove = 1'b1;
            if (stat.act == ACT_LEAVE) begin
              cmd.leave = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_GCHK;
            end
          end
        end
      end
      S_GCHK: begin
        // The table is only searched for its head when the counts already allow a grant.
        if (stat.grant_ok) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_HEAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HEAD: begin
        if (stat.scan_done) begin
          cmd.set_grant = stat.found && stat.head_own;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/lamport_mutex_node_unit.sv @@
// One node of timestamp-ordered distributed mutual exclusion.
// Messages arrive as words on in_ch (action, sending peer, stamp of a peer request).
// Every accepted word gives exactly one result word on out_ch: the message to send
// (request broadcast, acknowledgement to the peer, release broadcast or none), a grant
// flag and an error code. own_id and peer_count are written through cfg_ch, which is
// always ready. The user must see that it is written only while the node is idle;
// the block does not enforce it. One word is handled at a time. A request or an unused
// action needs no walk of the table. A release or leave walks the request table memory,
// one entry a cycle through its single read port. When the counts then allow a grant,
// after an acknowledgement or a release that removes an entry, a walk for the table
// head follows. in_ch is ready only between words, so the next word is taken only
// after the previous result has been issued.
// The result sits in an output register; a new word is accepted while it waits, and
// the node holds back the next result until out_ch has taken the previous one.
// After reset the table is empty, the clock and acknowledgement count are zero,
// own_id is 0 and peer_count is 1; no clearing pass is needed.
// Depends on lmn_pkg, the channel interfaces, lmn_ctrl and lmn_datapath.
module lamport_mutex_node_unit import lmn_pkg::*; #(
  parameter int MAX_NODES  = LMN_MAX_NODES,
  parameter int STAMP_BITS = LMN_STAMP_BITS
) (
  input logic       clk,
  input logic       rst_n,
  lmn_in_if.sink    in_ch,
  lmn_out_if.source out_ch,
  lmn_cfg_if.sink   cfg_ch
);

  lmn_cmd_t  cmd;
  lmn_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  lmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmn_datapath #(
    .MAX_NODES  (MAX_NODES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_ch.action),
    .in_peer_id     (in_ch.peer_id),
    .in_stamp       (in_ch.stamp),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_send_kind  (out_ch.send_kind),
    .out_dest_id    (out_ch.dest_id),
    .out_send_stamp (out_ch.send_stamp),
    .out_grant      (out_ch.grant),
    .out_error      (out_ch.error)
  );

endmodule

@@ tb/sv/lmn_tb_pkg.sv @@
// Reply word type and scoreboard for the mutex node testbench.
// Depends on lmn_pkg for field widths, action, send and error codes.
package lmn_tb_pkg;
  import lmn_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]  send_kind;
    logic [NODE_W-1:0]  dest_id;
    logic [STAMP_W-1:0] send_stamp;
    logic               grant;
    logic [ERR_W-1:0]   error;
  } node_reply_t;

  class mutex_node_scoreboard;
    logic [NODE_W-1:0]  own_id = '0;
    logic [NODE_W-1:0]  peer_count = NODE_W'(1);
    logic [STAMP_W-1:0] slot_stamp [LMN_MAX_NODES];
    logic [NODE_W-1:0]  slot_node [LMN_MAX_NODES];
    bit                 slot_used [LMN_MAX_NODES];
    logic [ACK_W-1:0]   acks_seen = '0;
    logic [STAMP_W-1:0] request_stamp = '0;
    bit                 in_section = 1'b0;
    node_reply_t        replies_due [$];
    int mismatches = 0;
    int replies_checked = 0;
    int grants_due = 0;
    int full_errors = 0;
    int missing_errors = 0;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] reg_index,
                                 logic [CFG_DATA_W-1:0] data);
      if (reg_index == CFG_OWN_ID) own_id = data;
      else if (reg_index == CFG_PEER_COUNT) peer_count = data;
    endfunction

    // Lowest (stamp, node) entry in use, optionally only among one node's entries.
    // A strict compare keeps the lowest table index first on equal keys.
    function int oldest_slot(bit by_node, logic [NODE_W-1:0] node);
      int best;
      best = -1;
      for (int i = 0; i < LMN_MAX_NODES; i++) begin
        if (slot_used[i] && (!by_node || slot_node[i] == node)) begin
          if (best < 0 || {slot_stamp[i], slot_node[i]} < {slot_stamp[best], slot_node[best]})
            best = i;
        end
      end
      return best;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (slot_used[i]) if (slot_used[i]) n++;
      return n;
    endfunction

    // Node owning the head of the request table, or -1 when the table is empty.
    function int head_owner();
      int idx;
      idx = oldest_slot(1'b0, '0);
      if (idx < 0) return -1;
      return int'(slot_node[idx]);
    endfunction

    function bit insert_slot(logic [STAMP_W-1:0] stamp, logic [NODE_W-1:0] node);
      for (int i = 0; i < LMN_MAX_NODES; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_stamp[i] = stamp;
          slot_node[i] = node;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit try_grant();
      int idx;
      if (in_section || acks_seen != peer_count) return 1'b0;
      idx = oldest_slot(1'b0, '0);
      if (idx < 0 || slot_node[idx] != own_id) return 1'b0;
      in_section = 1'b1;
      return 1'b1;
    endfunction

    // Works out the reply to an accepted word and queues it.
    function void note_word(logic [ACT_W-1:0] action, logic [NODE_W-1:0] peer,
                            logic [STAMP_W-1:0] stamp);
      node_reply_t r;
      int idx;
      r = '0;
      case (action)
        ACT_LREQ: begin
          if (used_slots() == LMN_MAX_NODES) begin
            r.error = ERR_FULL;
          end else begin
            request_stamp = request_stamp + 1'b1;
            void'(insert_slot(request_stamp, own_id));
            r.send_kind = SEND_REQ;
            r.send_stamp = request_stamp;
          end
        end
        ACT_PREQ: begin
          if (!insert_slot(stamp, peer)) begin
            r.error = ERR_FULL;
          end else begin
            r.send_kind = SEND_ACK;
            r.dest_id = peer;
          end
        end
        ACT_PACK: begin
          if (acks_seen != ACK_MAX) acks_seen = acks_seen + 1'b1;
          r.grant = try_grant();
        end
        ACT_PREL: begin
          idx = oldest_slot(1'b1, peer);
          if (idx < 0) begin
            r.error = ERR_MISSING;
          end else begin
            slot_used[idx] = 1'b0;
            r.grant = try_grant();
          end
        end
        ACT_LEAVE: begin
          idx = oldest_slot(1'b1, own_id);
          if (idx < 0) begin
            r.error = ERR_MISSING;
          end else begin
            slot_used[idx] = 1'b0;
            acks_seen = '0;
            in_section = 1'b0;
            r.send_kind = SEND_REL;
          end
        end
        default: ;
      endcase
      if (r.grant) grants_due++;
      if (r.error == ERR_FULL) full_errors++;
      if (r.error == ERR_MISSING) missing_errors++;
      replies_due.push_back(r);
    endfunction

    function void check_reply(node_reply_t got);
      node_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply word with nothing outstanding: kind=%0d dest=%0d stamp=%h",
                   $realtime, got.send_kind, got.dest_id, got.send_stamp,
                   " grant=%0d err=%0d", got.grant, got.error);
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: reply %0d differs", $realtime, replies_checked);
          $display("  expected kind=%0d dest=%0d stamp=%h grant=%0d err=%0d",
                   want.send_kind, want.dest_id, want.send_stamp, want.grant, want.error);
          $display("  actual   kind=%0d dest=%0d stamp=%h grant=%0d err=%0d",
                   got.send_kind, got.dest_id, got.send_stamp, got.grant, got.error);
        end
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_lamport_mutex_node_unit.sv @@
// Top-level testbench for lamport_mutex_node_unit: directed message words, then random
// request sessions, table floods and acknowledgement storms over several settings.
// Depends on lmn_pkg, the three channel interfaces, lmn_tb_pkg and the block itself.
module tb_lamport_mutex_node_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lmn_pkg::*;
  import lmn_tb_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int PHASES = 7;
  localparam int WORDS_PER_PHASE = 250;
  // Longest walk of the table: a release whose grant check needs a second pass.
  localparam int NODE_QUIET = 2 * LMN_MAX_NODES + 12;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst_n;

  lmn_in_if  in_ch ();
  lmn_out_if out_ch ();
  lmn_cfg_if cfg_ch ();

  lamport_mutex_node_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mutex_node_scoreboard board = new();
  int  words_sent = 0;
  int  settings_used = 1;
  int  sink_hold_cycles = 0;
  bit  sender_burst = 1'b0;
  bit  sink_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("tb_lamport_mutex_node_unit failed");
    $finish;
  end

  // Offers one word and waits until the node takes it.
  task automatic send_word(logic [ACT_W-1:0] action, logic [NODE_W-1:0] peer,
                           logic [STAMP_W-1:0] stamp);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= action;
    in_ch.peer_id <= peer;
    in_ch.stamp <= stamp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_word(action, peer, stamp);
    if (action <= ACT_LEAVE) words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.write_register(reg_index, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_node();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (NODE_QUIET) @(posedge clk);
  endtask

  // Takes entries off the head of the table: releases for peers, a leave for our own.
  task automatic drop_head_entries(int budget, bit stop_at_own);
    int owner;
    owner = board.head_owner();
    while (budget > 0 && owner >= 0 && !(stop_at_own && owner == int'(board.own_id))) begin
      if (owner == int'(board.own_id))
        send_word(ACT_LEAVE, NODE_W'($urandom_range(0, 15)), STAMP_W'($urandom_range(0, 65535)));
      else
        send_word(ACT_PREL, NODE_W'(owner), STAMP_W'($urandom_range(0, 65535)));
      budget--;
      owner = board.head_owner();
    end
  endtask

  // The sink stalls at random, in bursts without stalls, and once for a long hold.
  initial begin
    int stall;
    node_reply_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, 13);
      end
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.send_kind = out_ch.send_kind;
      got.dest_id = out_ch.dest_id;
      got.send_stamp = out_ch.send_stamp;
      got.grant = out_ch.grant;
      got.error = out_ch.error;
      board.check_reply(got);
    end
  end

  initial begin
    int pick;
    int n_peers;
    bit releases_first;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= '0;
    in_ch.peer_id <= '0;
    in_ch.stamp <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset settings: own node 0, one acknowledgement needed.
    send_word(ACT_LEAVE, 4'hF, 16'hFFFF);   // nothing of ours to withdraw
    send_word(ACT_PREL, 4'h9, 16'h0000);    // release from a peer with no entry
    send_word(ACT_RSVD5, 4'hF, 16'hFFFF);
    send_word(ACT_RSVD6, 4'h0, 16'h0000);
    send_word(ACT_RSVD7, 4'hA, 16'h5555);
    send_word(ACT_PACK, 4'h1, 16'h0000);    // counted, but no own entry yet
    send_word(ACT_LREQ, 4'h0, 16'hAAAA);
    send_word(ACT_PREQ, 4'hF, 16'hFFFF);
    send_word(ACT_PREQ, 4'h3, 16'h0000);
    send_word(ACT_PREL, 4'h3, 16'h0000);    // our entry comes to the head: grant on release
    send_word(ACT_PACK, 4'h2, 16'h0000);    // already inside the section
    send_word(ACT_PREQ, 4'h7, 16'h0001);    // same stamp as ours, lower node wins
    send_word(ACT_PREQ, 4'h7, 16'h0000);
    send_word(ACT_PREL, 4'h7, 16'h0000);    // removes the lower of node 7's two entries
    send_word(ACT_LEAVE, 4'h0, 16'h0000);
    send_word(ACT_LREQ, 4'h0, 16'h0000);
    send_word(ACT_PACK, 4'h5, 16'h0000);    // node 7 still ahead of us
    send_word(ACT_PREL, 4'h7, 16'h0000);
    send_word(ACT_LEAVE, 4'h0, 16'h0000);
    send_word(ACT_LEAVE, 4'h0, 16'h0000);
    send_word(ACT_PREL, 4'hF, 16'h0000);
    send_word(ACT_PREL, 4'hF, 16'h0000);
    send_word(ACT_LREQ, 4'h0, 16'h0000);
    send_word(ACT_PACK, 4'h4, 16'h0000);    // grant on the acknowledgement
    send_word(ACT_LEAVE, 4'h0, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle_node();
      write_reg(CFG_OWN_ID, phase == 0 ? 4'd15 : phase == 1 ? 4'd0 :
                CFG_DATA_W'($urandom_range(0, 15)));
      write_reg(CFG_PEER_COUNT,
                phase == 0 ? 4'd15 : phase == 1 ? 4'd1 : CFG_DATA_W'($urandom_range(1, 4)));
      settings_used++;
      // Let the node back up behind a long stall of the sink.
      if (phase == 2) sink_hold_cycles = LONG_HOLD;
      while (words_sent < (phase + 1) * WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // A full request session: request, competing peers, releases and acknowledgements, leave.
          send_word(ACT_LREQ, NODE_W'($urandom_range(0, 15)),
                    STAMP_W'($urandom_range(0, 65535)));
          n_peers = $urandom_range(0, 3);
          repeat (n_peers)
            send_word(ACT_PREQ, NODE_W'($urandom_range(0, 15)),
                      STAMP_W'(board.request_stamp + $urandom_range(0, 4) - 2));
          if ($urandom_range(0, 9) == 0) begin
            // Withdraw before the grant.
            send_word(ACT_LEAVE, NODE_W'($urandom_range(0, 15)),
                      STAMP_W'($urandom_range(0, 65535)));
          end else begin
            releases_first = 1'($urandom_range(0, 1));
            if (releases_first) drop_head_entries($urandom_range(0, 5), 1'b1);
            repeat (board.peer_count)
              send_word(ACT_PACK, NODE_W'($urandom_range(0, 15)),
                        STAMP_W'($urandom_range(0, 65535)));
            if (!releases_first) drop_head_entries($urandom_range(0, 5), 1'b1);
            if ($urandom_range(0, 3) == 0)
              send_word(ACT_PACK, NODE_W'($urandom_range(0, 15)),
                        STAMP_W'($urandom_range(0, 65535)));
            send_word(ACT_LEAVE, NODE_W'($urandom_range(0, 15)),
                      STAMP_W'($urandom_range(0, 65535)));
          end
        end else if (pick < 65) begin
          // Fill the table, knock on it while full, then drain most of it.
          while (board.used_slots() < LMN_MAX_NODES)
            send_word(ACT_PREQ, NODE_W'($urandom_range(0, 15)),
                      STAMP_W'($urandom_range(0, 65535)));
          send_word(ACT_PREQ, NODE_W'($urandom_range(0, 15)),
                    STAMP_W'($urandom_range(0, 65535)));
          send_word(ACT_LREQ, NODE_W'($urandom_range(0, 15)),
                    STAMP_W'($urandom_range(0, 65535)));
          drop_head_entries(board.used_slots() - $urandom_range(0, 3), 1'b0);
        end else if (pick < 72) begin
          // Enough acknowledgements to reach or come close to saturating the count.
          repeat ($urandom_range(14, 18))
            send_word(ACT_PACK, NODE_W'($urandom_range(0, 15)),
                      STAMP_W'($urandom_range(0, 65535)));
        end else begin
          repeat ($urandom_range(1, 4))
            send_word(ACT_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 15)),
                      STAMP_W'($urandom_range(0, 65535)));
        end
      end
    end

    settle_node();
    $display("Sent %0d message words under %0d register settings; %0d replies checked.",
             words_sent, settings_used, board.replies_checked);
    $display("Replies included %0d grants, %0d table-full and %0d missing-entry errors.",
             board.grants_due, board.full_errors, board.missing_errors);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_lamport_mutex_node_unit passed");
    end else begin
      $display("%0d mismatching replies, %0d replies never arrived",
               board.mismatches, board.pending());
      $display("tb_lamport_mutex_node_unit failed");
    end
    $finish;
  end

endmodule
